### hdl/dbfr_pkg.sv
// ============================================================================
// dbfr_pkg
// Shared constants, types and the frame byte table for the debounced button
// command framer.
// ============================================================================
package dbfr_pkg;

   // Debounce counter and setting widths
   localparam int COUNT_WIDTH = 16;
   localparam int TICKS_WIDTH = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > TICKS_WIDTH) ? COUNT_WIDTH : TICKS_WIDTH;

   // Volume widths and ceiling
   localparam int VOL_WIDTH     = 6;
   localparam int SAT_VOL_WIDTH = 5;
   localparam logic [VOL_WIDTH-1:0]     VOL_MAX     = 6'd30;
   localparam logic [SAT_VOL_WIDTH-1:0] VOL_MAX_SAT = 5'd30;

   // Register port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_DEBOUNCE_TICKS = 1'b0;
   localparam logic REG_VOLUME_LEVEL   = 1'b1;

   // Frame bytes
   localparam logic [7:0] FRAME_HEAD = 8'hAA;
   localparam logic [7:0] OP_PLAY    = 8'h02;
   localparam logic [7:0] OP_STOP    = 8'h04;
   localparam logic [7:0] OP_VOLUME  = 8'h13;
   localparam logic [7:0] LEN_ZERO   = 8'h00;
   localparam logic [7:0] LEN_ONE    = 8'h01;
   localparam logic [7:0] SUM_PLAY   = 8'hAC;
   localparam logic [7:0] SUM_STOP   = 8'hAE;

   // Byte positions within the run of one tick
   localparam int IDX_WIDTH = 4;
   localparam logic [IDX_WIDTH-1:0] IDX_PLAY_HEAD = 4'd0;
   localparam logic [IDX_WIDTH-1:0] IDX_PLAY_CMD  = 4'd1;
   localparam logic [IDX_WIDTH-1:0] IDX_PLAY_LEN  = 4'd2;
   localparam logic [IDX_WIDTH-1:0] IDX_PLAY_SUM  = 4'd3;
   localparam logic [IDX_WIDTH-1:0] IDX_VOL_HEAD  = 4'd4;
   localparam logic [IDX_WIDTH-1:0] IDX_VOL_CMD   = 4'd5;
   localparam logic [IDX_WIDTH-1:0] IDX_VOL_LEN   = 4'd6;
   localparam logic [IDX_WIDTH-1:0] IDX_VOL_VAL   = 4'd7;
   localparam logic [IDX_WIDTH-1:0] IDX_VOL_SUM   = 4'd8;
   localparam logic [IDX_WIDTH-1:0] IDX_STOP_HEAD = 4'd9;
   localparam logic [IDX_WIDTH-1:0] IDX_STOP_CMD  = 4'd10;
   localparam logic [IDX_WIDTH-1:0] IDX_STOP_LEN  = 4'd11;
   localparam logic [IDX_WIDTH-1:0] IDX_STOP_SUM  = 4'd12;

   // Command queue depth
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   // One classified tick that causes frames
   typedef struct packed {
      logic                     play;
      logic                     stop;
      logic [SAT_VOL_WIDTH-1:0] vol;
      logic                     playing;
   } cmd_type;

   // Byte at a run position, with the volume frame built from vol
   function automatic logic [7:0] frame_byte_at(input logic [IDX_WIDTH-1:0]     idx,
                                                 input logic [SAT_VOL_WIDTH-1:0] vol);
      logic [7:0] vol_byte;
      logic [7:0] res;
      vol_byte = {{(8-SAT_VOL_WIDTH){1'b0}}, vol};
      case (idx)
         IDX_PLAY_HEAD: res = FRAME_HEAD;
         IDX_PLAY_CMD:  res = OP_PLAY;
         IDX_PLAY_LEN:  res = LEN_ZERO;
         IDX_PLAY_SUM:  res = SUM_PLAY;
         IDX_VOL_HEAD:  res = FRAME_HEAD;
         IDX_VOL_CMD:   res = OP_VOLUME;
         IDX_VOL_LEN:   res = LEN_ONE;
         IDX_VOL_VAL:   res = vol_byte;
         IDX_VOL_SUM:   res = 8'(FRAME_HEAD + OP_VOLUME + LEN_ONE + vol_byte);
         IDX_STOP_HEAD: res = FRAME_HEAD;
         IDX_STOP_CMD:  res = OP_STOP;
         IDX_STOP_LEN:  res = LEN_ZERO;
         IDX_STOP_SUM:  res = SUM_STOP;
         default:       res = LEN_ZERO;
      endcase
      return res;
   endfunction

endpackage

### hdl/dbfr_front.sv
// ============================================================================
// dbfr_front
// Debounces both buttons on each accepted tick, tracks the playing flag and
// emits one command for every tick that has a debounced press.
// ============================================================================
module dbfr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               play_level,
   input  logic                               stop_level,
   input  logic [dbfr_pkg::TICKS_WIDTH-1:0]   debounce_ticks,
   input  logic [dbfr_pkg::SAT_VOL_WIDTH-1:0] sat_vol,
   output logic                               cmd_push,
   output dbfr_pkg::cmd_type                  cmd_data
);
   import dbfr_pkg::*;

   typedef struct packed {
      logic                   stable;
      logic [COUNT_WIDTH-1:0] elapsed;
      logic                   press;
   } deb_type;

   logic                   play_stable_ff, play_stable_in;
   logic                   stop_stable_ff, stop_stable_in;
   logic [COUNT_WIDTH-1:0] play_elapsed_ff, play_elapsed_in;
   logic [COUNT_WIDTH-1:0] stop_elapsed_ff, stop_elapsed_in;
   logic                   playing_ff, playing_in;
   deb_type                play_deb, stop_deb;

   // Step one debouncer for one tick
   function automatic deb_type deb_step(input logic                   level,
                                        input logic                   stable,
                                        input logic [COUNT_WIDTH-1:0] elapsed,
                                        input logic [TICKS_WIDTH-1:0] ticks);
      deb_type r;
      r.stable  = stable;
      r.elapsed = elapsed;
      r.press   = 1'b0;
      if (level != stable) begin
         if (CMP_WIDTH'(elapsed) >= CMP_WIDTH'(ticks)) begin
            r.press   = stable & ~level;
            r.stable  = level;
            r.elapsed = '0;
         end else if (elapsed != '1) begin
            r.elapsed = elapsed + 1'b1;
         end
      end else begin
         r.elapsed = '0;
      end
      return r;
   endfunction

   // Classify the tick
   always_comb begin
      play_deb = deb_step(play_level, play_stable_ff, play_elapsed_ff, debounce_ticks);
      stop_deb = deb_step(stop_level, stop_stable_ff, stop_elapsed_ff, debounce_ticks);
      play_stable_in  = play_deb.stable;
      play_elapsed_in = play_deb.elapsed;
      stop_stable_in  = stop_deb.stable;
      stop_elapsed_in = stop_deb.elapsed;
      playing_in = playing_ff;
      if (play_deb.press) begin
         playing_in = 1'b1;
      end
      if (stop_deb.press) begin
         playing_in = 1'b0;
      end
   end

   // Hand a command on only when the tick causes frames
   assign cmd_push         = accept & (play_deb.press | stop_deb.press);
   assign cmd_data.play    = play_deb.press;
   assign cmd_data.stop    = stop_deb.press;
   assign cmd_data.vol     = sat_vol;
   assign cmd_data.playing = playing_in;

   // Hold debouncer state between ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         play_stable_ff  <= 1'b1;
         stop_stable_ff  <= 1'b1;
         play_elapsed_ff <= '0;
         stop_elapsed_ff <= '0;
         playing_ff      <= 1'b0;
      end else if (accept) begin
         play_stable_ff  <= play_stable_in;
         stop_stable_ff  <= stop_stable_in;
         play_elapsed_ff <= play_elapsed_in;
         stop_elapsed_ff <= stop_elapsed_in;
         playing_ff      <= playing_in;
      end
   end

endmodule

### hdl/dbfr_cmdq.sv
// ============================================================================
// dbfr_cmdq
// Short command queue between the debounce front and the frame serializer.
// ============================================================================
module dbfr_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dbfr_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output dbfr_pkg::cmd_type pop_data,
   output logic              empty
);
   import dbfr_pkg::*;

   cmd_type              entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CMDQ_CW'(CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? CMDQ_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? CMDQ_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/dbfr_back.sv
// ============================================================================
// dbfr_back
// Expands each queued command into its frame bytes, one item per cycle while
// the receiver keeps popping, through a registered output stage.
// ============================================================================
module dbfr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  dbfr_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic [7:0]        out_byte,
   output logic              out_last,
   output logic              out_playing,
   output logic              out_empty,
   input  logic              out_pop
);
   import dbfr_pkg::*;

   logic                 cur_valid_ff, cur_valid_in;
   cmd_type              cur_ff, cur_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_playing_ff, out_playing_in;
   logic                 load_out, last_byte, finishing, take_cmd;
   logic [IDX_WIDTH-1:0] end_idx;

   // Decide what moves this cycle
   always_comb begin
      end_idx   = cur_ff.stop ? IDX_STOP_SUM : IDX_VOL_SUM;
      load_out  = cur_valid_ff & (~out_valid_ff | out_pop);
      last_byte = (idx_ff == end_idx);
      finishing = load_out & last_byte;
      take_cmd  = ~q_empty & (~cur_valid_ff | finishing);
   end

   assign q_pop = take_cmd;

   // Advance the run and load the output stage
   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      cur_valid_in = cur_valid_ff;
      if (take_cmd) begin
         cur_in       = q_data;
         idx_in       = q_data.play ? IDX_PLAY_HEAD : IDX_STOP_HEAD;
         cur_valid_in = 1'b1;
      end else if (finishing) begin
         cur_valid_in = 1'b0;
      end else if (load_out) begin
         idx_in = idx_ff + 1'b1;
      end
      out_byte_in    = frame_byte_at(idx_ff, cur_ff.vol);
      out_last_in    = last_byte;
      out_playing_in = cur_ff.playing;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (load_out) begin
         out_byte_ff    <= out_byte_in;
         out_last_ff    <= out_last_in;
         out_playing_ff <= out_playing_in;
      end
   end

   assign out_byte    = out_byte_ff;
   assign out_last    = out_last_ff;
   assign out_playing = out_playing_ff;
   assign out_empty   = ~out_valid_ff;

endmodule

### hdl/debounced_button_command_framer_top.sv
// ============================================================================
// debounced_button_command_framer_top
// Debounced play and stop buttons turned into serial command frames.
// ============================================================================
// A tick is taken in every cycle that full is low; its debounce work is done
// at the accepting edge, so a tick that causes no frame produces no item. A
// debounced play press yields 9 items (play frame and volume frame), a stop
// press 4, both in one tick 13. Items leave one per cycle, while the receiver
// pops, from a registered output stage; up to 4 pressing ticks wait in the
// command queue before full rises. Every item of a tick carries the playing
// flag as it stands after that tick, and last_of_run marks its final item.
// The registers debounce_ticks (address 0) and volume_level (address 4) are
// written through the register port; the user must write them only while
// the block is idle, and the block itself does not enforce this.
module debounced_button_command_framer_top (
   input  logic                                clock,
   input  logic                                reset,
   // Tick input
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_play_level,
   input  logic                                req_stop_level,
   // Frame byte output
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [7:0]                          rsp_frame_byte,
   output logic                                rsp_last_of_run,
   output logic                                rsp_is_playing,
   // Register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dbfr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [dbfr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [dbfr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import dbfr_pkg::*;

   logic [TICKS_WIDTH-1:0]   debounce_ticks_ff;
   logic [VOL_WIDTH-1:0]     volume_level_ff;
   logic [SAT_VOL_WIDTH-1:0] sat_vol;
   logic                     csr_write;
   logic                     reg_sel;
   logic                     accept;
   logic                     cmd_push, q_full, q_empty, q_pop;
   cmd_type                  cmd_data, q_data;

   // Register write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= TICKS_WIDTH'(50);
         volume_level_ff   <= VOL_WIDTH'(20);
      end else if (csr_write) begin
         case (reg_sel)
            REG_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_pwdata[TICKS_WIDTH-1:0];
            REG_VOLUME_LEVEL:   volume_level_ff   <= csr_pwdata[VOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEBOUNCE_TICKS: csr_prdata = CSR_DATA_WIDTH'(debounce_ticks_ff);
         REG_VOLUME_LEVEL:   csr_prdata = CSR_DATA_WIDTH'(volume_level_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Clamp volume to the ceiling
   assign sat_vol = (volume_level_ff > VOL_MAX) ? VOL_MAX_SAT
                                                : volume_level_ff[SAT_VOL_WIDTH-1:0];

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   dbfr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .play_level     (req_play_level),
      .stop_level     (req_stop_level),
      .debounce_ticks (debounce_ticks_ff),
      .sat_vol        (sat_vol),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_data)
   );

   dbfr_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   dbfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .out_byte    (rsp_frame_byte),
      .out_last    (rsp_last_of_run),
      .out_playing (rsp_is_playing),
      .out_empty   (rsp_empty),
      .out_pop     (rsp_pop)
   );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the debounced button command framer. Ticks of
// button levels go in through the push/full side, and frame bytes come out
// through the empty/pop side. A predictor runs the two debouncers and the
// frame builder on every accepted tick and queues the bytes it expects.
// The monitor checks each popped byte against the oldest expected byte.
// ============================================================================
module testbench;
   import dbfr_pkg::*;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_DEBOUNCE = {REG_DEBOUNCE_TICKS, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_VOLUME   = {REG_VOLUME_LEVEL, 2'b00};
   localparam int RUN_MAX    = 13;
   localparam int HOLD_TICKS = 400;

   typedef struct packed {
      logic play;
      logic stop;
   } tick_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_run;
      logic       is_playing;
   } frame_item_type;

   typedef struct packed {
      logic                   stable;
      logic [COUNT_WIDTH-1:0] elapsed;
   } button_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_push       = 1'b0;
   logic                      req_full;
   logic                      req_play_level = 1'b1;
   logic                      req_stop_level = 1'b1;
   logic                      rsp_empty;
   logic                      rsp_pop        = 1'b0;
   logic [7:0]                rsp_frame_byte;
   logic                      rsp_last_of_run;
   logic                      rsp_is_playing;
   logic                      csr_psel       = 1'b0;
   logic                      csr_penable    = 1'b0;
   logic                      csr_pwrite     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr      = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // Predictor state and settings, as after reset
   logic [TICKS_WIDTH-1:0] model_ticks   = 16'd50;
   logic [VOL_WIDTH-1:0]   model_vol     = 6'd20;
   button_type             model_play    = '{stable: 1'b1, elapsed: '0};
   button_type             model_stop    = '{stable: 1'b1, elapsed: '0};
   logic                   model_playing = 1'b0;

   tick_type       ticks_waiting[$];
   frame_item_type frames_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;
   bit hold_taken    = 1'b0;
   int hold_left     = 0;
   int error_count   = 0;

   debounced_button_command_framer_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_play_level  (req_play_level),
      .req_stop_level  (req_stop_level),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_is_playing  (rsp_is_playing),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance one debouncer by one tick
   function automatic button_type next_button(button_type b, logic lvl);
      button_type nb;
      nb = b;
      if (lvl != b.stable) begin
         if (b.elapsed >= model_ticks) begin
            nb.stable  = lvl;
            nb.elapsed = '0;
         end else if (b.elapsed != '1) begin
            nb.elapsed = b.elapsed + 1'b1;
         end
      end else begin
         nb.elapsed = '0;
      end
      return nb;
   endfunction

   function automatic logic is_press(button_type b, logic lvl);
      return b.stable && !lvl && (b.elapsed >= model_ticks);
   endfunction

   // Work out the frame bytes one accepted tick causes
   task automatic predict_frames(input logic play_lvl, input logic stop_lvl);
      logic [7:0]     run[RUN_MAX];
      logic [7:0]     vol_byte;
      frame_item_type fi;
      int             n;
      n = 0;
      vol_byte = (model_vol > VOL_MAX) ? 8'(VOL_MAX) : 8'(model_vol);
      if (is_press(model_play, play_lvl)) begin
         run[0] = FRAME_HEAD;
         run[1] = OP_PLAY;
         run[2] = LEN_ZERO;
         run[3] = SUM_PLAY;
         run[4] = FRAME_HEAD;
         run[5] = OP_VOLUME;
         run[6] = LEN_ONE;
         run[7] = vol_byte;
         run[8] = 8'(FRAME_HEAD + OP_VOLUME + LEN_ONE + vol_byte);
         n = 9;
         model_playing = 1'b1;
      end
      model_play = next_button(model_play, play_lvl);
      if (is_press(model_stop, stop_lvl)) begin
         run[n]     = FRAME_HEAD;
         run[n + 1] = OP_STOP;
         run[n + 2] = LEN_ZERO;
         run[n + 3] = SUM_STOP;
         n = n + 4;
         model_playing = 1'b0;
      end
      model_stop = next_button(model_stop, stop_lvl);
      for (int k = 0; k < n; k++) begin
         fi.frame_byte  = run[k];
         fi.last_of_run = (k == n - 1);
         fi.is_playing  = model_playing;
         frames_due.push_back(fi);
      end
   endtask

   // Driver: offer the oldest waiting tick, hold it until taken
   always @(posedge clock) begin : driver
      logic offer_next;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         offer_next = req_push;
         if (req_push && !req_full) begin
            predict_frames(req_play_level, req_stop_level);
            void'(ticks_waiting.pop_front());
            offer_next = 1'b0;
         end
         if (!offer_next && ticks_waiting.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_play_level <= ticks_waiting[0].play;
            req_stop_level <= ticks_waiting[0].stop;
            offer_next = 1'b1;
         end
         req_push <= offer_next;
      end
   end

   // Hold off the receiver once for a long stretch so the block backs up
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_TICKS;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: check each popped item, then pick the next pop
   always @(posedge clock) begin : monitor
      frame_item_type due;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (frames_due.size() == 0) begin
               $error("unexpected item: frame_byte %02h", rsp_frame_byte);
               error_count++;
            end else begin
               due = frames_due.pop_front();
               if (rsp_frame_byte !== due.frame_byte) begin
                  $error("frame_byte expected %02h actual %02h",
                         due.frame_byte, rsp_frame_byte);
                  error_count++;
               end
               if (rsp_last_of_run !== due.last_of_run) begin
                  $error("last_of_run expected %0b actual %0b",
                         due.last_of_run, rsp_last_of_run);
                  error_count++;
               end
               if (rsp_is_playing !== due.is_playing) begin
                  $error("is_playing expected %0b actual %0b",
                         due.is_playing, rsp_is_playing);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // One register write: setup, access, wait for pready
   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_DEBOUNCE) model_ticks = data[TICKS_WIDTH-1:0];
      else if (addr == ADDR_VOLUME) model_vol = data[VOL_WIDTH-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Set both registers, with random upper bits that the block drops
   task automatic set_config(input int ticks, input int vol);
      logic [CSR_DATA_WIDTH-1:0] data;
      data = $urandom;
      data[TICKS_WIDTH-1:0] = TICKS_WIDTH'(ticks);
      write_csr(ADDR_DEBOUNCE, data);
      data = $urandom;
      data[VOL_WIDTH-1:0] = VOL_WIDTH'(vol);
      write_csr(ADDR_VOLUME, data);
      @(negedge clock);
   endtask

   // Wait until every tick is taken and every expected item has come
   task automatic settle();
      do @(negedge clock);
      while (ticks_waiting.size() != 0 || req_push || frames_due.size() != 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic add_ticks(input logic play, input logic stop, input int count);
      tick_type t;
      t.play = play;
      t.stop = stop;
      repeat (count) ticks_waiting.push_back(t);
   endtask

   // Mostly level runs long enough to pass the debouncer, some short glitches
   task automatic add_random(input int target);
      int added;
      int len;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 99) < 85)
            len = int'(model_ticks) + 1 + int'($urandom_range(0, 2));
         else
            len = int'($urandom_range(1, int'(model_ticks) + 1));
         add_ticks(1'($urandom), 1'($urandom), len);
         added += len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every press combination with no debounce, volume above 30
      set_config(0, 63);
      add_ticks(1, 1, 1);
      add_ticks(0, 1, 2);
      add_ticks(1, 1, 1);
      add_ticks(1, 0, 1);
      add_ticks(1, 1, 1);
      add_ticks(0, 0, 1);
      add_ticks(1, 1, 1);
      add_ticks(0, 1, 1);
      add_ticks(1, 1, 1);
      add_ticks(0, 1, 1);
      add_ticks(1, 1, 1);
      settle();

      // Directed: one tick of debounce, a glitch that clears the count, zero volume
      set_config(1, 0);
      add_ticks(0, 1, 1);
      add_ticks(1, 1, 1);
      add_ticks(0, 1, 2);
      add_ticks(1, 1, 2);
      settle();
      set_config(0, 31);
      add_ticks(0, 0, 1);
      add_ticks(1, 1, 1);
      settle();

      // Longest debounce: a short press never gets through
      set_config(16'hFFFF, 30);
      add_ticks(1, 1, 2);
      add_ticks(0, 1, 20);
      add_ticks(1, 0, 3);
      settle();

      // Random, sender idles lightly and receiver heavily
      send_idle_pct = 24;
      recv_idle_pct = 81;
      set_config($urandom_range(0, 3), $urandom_range(0, 63));
      add_random(70);
      settle();

      // Random, the other way round
      send_idle_pct = 81;
      recv_idle_pct = 24;
      set_config($urandom_range(0, 6), $urandom_range(0, 63));
      add_random(70);
      settle();

      // Random with no idling, and one long receiver hold-off to fill the block
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(0, $urandom_range(0, 63));
      hold_request = 1'b1;
      add_random(70);
      settle();

      // Debounce back at its reset value
      send_idle_pct = 24;
      recv_idle_pct = 24;
      set_config(50, 30);
      add_random(100);
      settle();

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Timeout
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### files.f
hdl/dbfr_pkg.sv
hdl/dbfr_front.sv
hdl/dbfr_cmdq.sv
hdl/dbfr_back.sv
hdl/debounced_button_command_framer_top.sv
tb/sv/testbench.sv
